/* rtl/core/assert_macros.svh */
// Assertion macros shared by the rotation_matrix_to_quaternion RTL.
// Assumes a clock named clk and an active-high reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only outside reset.
`define ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/core/rmq_pkg.sv */
// Shared widths and lane codes for the rotation matrix to quaternion block.
// No dependencies.
`timescale 1ns / 1ps
package rmq_pkg;
  localparam int MAT_W  = 16;  // Q2.14 matrix element
  localparam int T_W    = 17;  // clamped diagonal sum
  localparam int MAG_W  = 15;  // candidate magnitude, Q2.13
  localparam int SQ_W   = 31;  // sum of squared magnitudes
  localparam int LEN_W  = 24;  // length, units of 2^-21
  localparam int QUO_W  = 15;  // normalized magnitude
  localparam int NUM_W  = 39;  // divider numerator
  localparam int DEN_W  = 25;  // divider denominator
  localparam int LANES  = 4;
  localparam logic [QUO_W-1:0] ONE_Q14 = 15'd16384;

  typedef logic [1:0] lane_t;
  localparam lane_t LANE_W = 2'd0;
  localparam lane_t LANE_X = 2'd1;
  localparam lane_t LANE_Y = 2'd2;
  localparam lane_t LANE_Z = 2'd3;

  typedef logic [T_W-1:0]   tsum_t;
  typedef logic [MAG_W-1:0] mag_t;
endpackage

/* rtl/core/rmq_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per register stage, several lanes.
// Depends on nothing; sideband bits travel alongside the lanes.
`timescale 1ns / 1ps
module rmq_sqrt_pipe #(
  parameter int LANES  = 4,
  parameter int IN_W   = 30,
  parameter int SIDE_W = 4
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 en,
  input  logic                                 in_valid,
  input  logic [LANES-1:0][IN_W-1:0]           in_rad,
  input  logic [SIDE_W-1:0]                    in_side,
  output logic                                 out_valid,
  output logic [LANES-1:0][IN_W/2-1:0]         out_root,
  output logic [SIDE_W-1:0]                    out_side
);
  localparam int N     = IN_W / 2;
  localparam int REM_W = N + 2;

  logic                            vld  [N+1];
  logic [LANES-1:0][IN_W-1:0]      rad  [N+1];
  logic [LANES-1:0][N-1:0]         root [N+1];
  logic [LANES-1:0][REM_W-1:0]     rem  [N+1];
  logic [SIDE_W-1:0]               side [N+1];

  assign vld[0]  = in_valid;
  assign rad[0]  = in_rad;
  assign root[0] = '0;
  assign rem[0]  = '0;
  assign side[0] = in_side;

  for (genvar s = 0; s < N; s++) begin : g_stage
    logic [LANES-1:0][IN_W-1:0]  rad_next;
    logic [LANES-1:0][N-1:0]     root_next;
    logic [LANES-1:0][REM_W-1:0] rem_next;

    always_comb begin
      logic [REM_W+1:0] cur;
      logic [REM_W+1:0] trial;
      for (int l = 0; l < LANES; l++) begin
        cur   = {rem[s][l], rad[s][l][IN_W-1 -: 2]};
        trial = {2'b00, root[s][l], 2'b01};
        rad_next[l] = {rad[s][l][IN_W-3:0], 2'b00};
        if (cur >= trial) begin
          rem_next[l]  = REM_W'(cur - trial);
          root_next[l] = {root[s][l][N-2:0], 1'b1};
        end else begin
          rem_next[l]  = cur[REM_W-1:0];
          root_next[l] = {root[s][l][N-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rad[s+1]  <= rad_next;
        root[s+1] <= root_next;
        rem[s+1]  <= rem_next;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[N];
  assign out_root  = root[N];
  assign out_side  = side[N];
endmodule

/* rtl/core/rmq_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, lanes share the divisor.
// Quotient must fit in Q_W bits; depends on nothing.
`timescale 1ns / 1ps
module rmq_div_pipe #(
  parameter int LANES  = 4,
  parameter int NUM_W  = 39,
  parameter int DEN_W  = 25,
  parameter int Q_W    = 15,
  parameter int SIDE_W = 4
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_valid,
  input  logic [LANES-1:0][NUM_W-1:0]   in_num,
  input  logic [DEN_W-1:0]              in_den,
  input  logic [SIDE_W-1:0]             in_side,
  output logic                          out_valid,
  output logic [LANES-1:0][Q_W-1:0]     out_quo,
  output logic [SIDE_W-1:0]             out_side
);
  localparam int HI_W = NUM_W - Q_W;

  logic                          vld  [Q_W+1];
  logic [LANES-1:0][NUM_W-1:0]   num  [Q_W+1];
  logic [DEN_W-1:0]              den  [Q_W+1];
  logic [LANES-1:0][DEN_W-1:0]   rem  [Q_W+1];
  logic [LANES-1:0][Q_W-1:0]     quo  [Q_W+1];
  logic [SIDE_W-1:0]             side [Q_W+1];

  assign vld[0]  = in_valid;
  assign num[0]  = in_num;
  assign den[0]  = in_den;
  assign quo[0]  = '0;
  assign side[0] = in_side;

  // High part of the numerator is already below the divisor.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      rem[0][l] = DEN_W'(in_num[l][NUM_W-1:Q_W]);
    end
  end

  for (genvar s = 0; s < Q_W; s++) begin : g_stage
    logic [LANES-1:0][DEN_W-1:0] rem_next;
    logic [LANES-1:0][Q_W-1:0]   quo_next;

    always_comb begin
      logic [DEN_W:0] cur;
      for (int l = 0; l < LANES; l++) begin
        cur = {rem[s][l], num[s][l][Q_W-1-s]};
        if (cur >= {1'b0, den[s]}) begin
          rem_next[l] = DEN_W'(cur - {1'b0, den[s]});
          quo_next[l] = {quo[s][l][Q_W-2:0], 1'b1};
        end else begin
          rem_next[l] = cur[DEN_W-1:0];
          quo_next[l] = {quo[s][l][Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (en) begin
        vld[s+1] <= vld[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num[s+1]  <= num[s];
        den[s+1]  <= den[s];
        rem[s+1]  <= rem_next;
        quo[s+1]  <= quo_next;
        side[s+1] <= side[s];
      end
    end
  end

  assign out_valid = vld[Q_W];
  assign out_quo   = quo[Q_W];
  assign out_side  = side[Q_W];
endmodule

/* rtl/core/rotation_matrix_to_quaternion.sv */
// Rotation matrix to unit quaternion, Q2.14 in and out.
// Uses rmq_pkg, rmq_sqrt_pipe, rmq_div_pipe and assert_macros.svh.
//
// Slave channel s_*: one 3x3 matrix per item. Master channel m_*: one
// quaternion (w, x, y, z) per item, same order as the input.
// Datapath: diagonal sums and off-diagonal signs, largest-term select,
// a 15-stage square root over four lanes, squares and their sum, a
// 24-stage square root for the length, operand prep, a 15-stage divider
// over four lanes, then saturation and sign.
// Throughput: one item per cycle while the output is not stalled; every stage is registered and the
// pipeline holds up to 60 items.
// Reset clears all valid bits; the pipeline comes up empty with s_tready high.
// Stall: the whole pipeline advances only when the output register is empty
// or being taken, so s_tready follows !m_tvalid || m_tready and a stall
// loses or repeats no item.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rotation_matrix_to_quaternion (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // m11, m12, m13, m21, m22, m23, m31, m32, m33 (16 bits each)
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // quat_w, quat_x, quat_y, quat_z (16 bits each)
  output logic [63:0]  m_tdata
);
  localparam int L = rmq_pkg::LANES;

  logic en;
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;

  // stage A: diagonal sums and sign bits
  logic signed [rmq_pkg::MAT_W-1:0] a11, a12, a13, a21, a22, a23, a31, a32, a33;
  assign a11 = s_tdata[15:0];
  assign a12 = s_tdata[31:16];
  assign a13 = s_tdata[47:32];
  assign a21 = s_tdata[63:48];
  assign a22 = s_tdata[79:64];
  assign a23 = s_tdata[95:80];
  assign a31 = s_tdata[111:96];
  assign a32 = s_tdata[127:112];
  assign a33 = s_tdata[143:128];

  logic signed [18:0] tw, tx, ty, tz;
  logic signed [16:0] d32, d13, d21, p21, p13, p32;
  always_comb begin
    tw  = 19'sd16384 + 19'(a11) + 19'(a22) + 19'(a33);
    tx  = 19'sd16384 + 19'(a11) - 19'(a22) - 19'(a33);
    ty  = 19'sd16384 - 19'(a11) + 19'(a22) - 19'(a33);
    tz  = 19'sd16384 - 19'(a11) - 19'(a22) + 19'(a33);
    d32 = 17'(a32) - 17'(a23);
    d13 = 17'(a13) - 17'(a31);
    d21 = 17'(a21) - 17'(a12);
    p21 = 17'(a21) + 17'(a12);
    p13 = 17'(a13) + 17'(a31);
    p32 = 17'(a32) + 17'(a23);
  end

  logic                           va;
  rmq_pkg::tsum_t [L-1:0]         ta;
  logic [5:0]                     sa;  // d32 d13 d21 p21 p13 p32 negative
  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= s_tvalid;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      ta[rmq_pkg::LANE_W] <= tw[18] ? '0 : tw[16:0];
      ta[rmq_pkg::LANE_X] <= tx[18] ? '0 : tx[16:0];
      ta[rmq_pkg::LANE_Y] <= ty[18] ? '0 : ty[16:0];
      ta[rmq_pkg::LANE_Z] <= tz[18] ? '0 : tz[16:0];
      sa <= {d32[16], d13[16], d21[16], p21[16], p13[16], p32[16]};
    end
  end

  // stage B: largest term and lane signs
  rmq_pkg::lane_t big;
  logic [L-1:0]   neg_b;
  always_comb begin
    big = rmq_pkg::LANE_W;
    if (ta[rmq_pkg::LANE_X] > ta[big]) big = rmq_pkg::LANE_X;
    if (ta[rmq_pkg::LANE_Y] > ta[big]) big = rmq_pkg::LANE_Y;
    if (ta[rmq_pkg::LANE_Z] > ta[big]) big = rmq_pkg::LANE_Z;
    neg_b = '0;
    case (big)
      rmq_pkg::LANE_W: begin
        neg_b[rmq_pkg::LANE_X] = sa[5];
        neg_b[rmq_pkg::LANE_Y] = sa[4];
        neg_b[rmq_pkg::LANE_Z] = sa[3];
      end
      rmq_pkg::LANE_X: begin
        neg_b[rmq_pkg::LANE_W] = sa[5];
        neg_b[rmq_pkg::LANE_Y] = sa[2];
        neg_b[rmq_pkg::LANE_Z] = sa[1];
      end
      rmq_pkg::LANE_Y: begin
        neg_b[rmq_pkg::LANE_W] = sa[4];
        neg_b[rmq_pkg::LANE_X] = sa[2];
        neg_b[rmq_pkg::LANE_Z] = sa[0];
      end
      default: begin
        neg_b[rmq_pkg::LANE_W] = sa[3];
        neg_b[rmq_pkg::LANE_X] = sa[1];
        neg_b[rmq_pkg::LANE_Y] = sa[0];
      end
    endcase
  end

  logic                   vb;
  rmq_pkg::tsum_t [L-1:0] tb;
  logic [L-1:0]           nb;
  rmq_pkg::lane_t         bigb;
  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      tb   <= ta;
      nb   <= neg_b;
      bigb <= big;
    end
  end

  // magnitudes: sqrt(t * 2^12)
  logic [L-1:0][29:0] rad1;
  always_comb begin
    for (int l = 0; l < L; l++) begin
      rad1[l] = {1'b0, tb[l], 12'd0};
    end
  end

  logic                   vm;
  logic [L-1:0][14:0]     mag_m;
  logic [L-1:0]           nm;
  rmq_sqrt_pipe #(.LANES(L), .IN_W(30), .SIDE_W(L)) u_mag_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vb), .in_rad(rad1), .in_side(nb),
    .out_valid(vm), .out_root(mag_m), .out_side(nm)
  );

  // squares
  logic                   vp;
  logic [L-1:0][29:0]     prod;
  rmq_pkg::mag_t [L-1:0]  mag_p;
  logic [L-1:0]           np;
  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= 1'b0;
    end else if (en) begin
      vp <= vm;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        prod[l] <= 30'(mag_m[l]) * 30'(mag_m[l]);
      end
      mag_p <= mag_m;
      np    <= nm;
    end
  end

  // sum of squares
  logic                      vs;
  logic [rmq_pkg::SQ_W-1:0]  sq;
  rmq_pkg::mag_t [L-1:0]     mag_s;
  logic [L-1:0]              ns;
  always_ff @(posedge clk) begin
    if (rst) begin
      vs <= 1'b0;
    end else if (en) begin
      vs <= vp;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sq    <= rmq_pkg::SQ_W'(prod[0]) + rmq_pkg::SQ_W'(prod[1])
             + rmq_pkg::SQ_W'(prod[2]) + rmq_pkg::SQ_W'(prod[3]);
      mag_s <= mag_p;
      ns    <= np;
    end
  end

  // length: sqrt(sq * 2^16)
  logic [0:0][47:0]                     rad2;
  logic [0:0][rmq_pkg::LEN_W-1:0]       len_r;
  logic                                 vl;
  logic [L*rmq_pkg::MAG_W+L-1:0]        side_l;
  assign rad2[0] = {1'b0, sq, 16'd0};

  rmq_sqrt_pipe #(.LANES(1), .IN_W(48), .SIDE_W(L*rmq_pkg::MAG_W+L)) u_len_sqrt (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vs), .in_rad(rad2), .in_side({mag_s, ns}),
    .out_valid(vl), .out_root(len_r), .out_side(side_l)
  );

  // divider operands
  rmq_pkg::mag_t [L-1:0]     mag_l;
  logic [L-1:0]              nl;
  logic [rmq_pkg::LEN_W-1:0] len_fix;
  assign mag_l   = side_l[L*rmq_pkg::MAG_W+L-1:L];
  assign nl      = side_l[L-1:0];
  assign len_fix = (len_r[0] == '0) ? rmq_pkg::LEN_W'(1) : len_r[0];

  logic                                vd;
  logic [L-1:0][rmq_pkg::NUM_W-1:0]    num_d;
  logic [rmq_pkg::DEN_W-1:0]           den_d;
  logic [L-1:0]                        nd;
  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vl;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < L; l++) begin
        num_d[l] <= rmq_pkg::NUM_W'({mag_l[l], 23'd0}) + rmq_pkg::NUM_W'(len_fix);
      end
      den_d <= {len_fix, 1'b0};
      nd    <= nl;
    end
  end

  logic                              vq;
  logic [L-1:0][rmq_pkg::QUO_W-1:0]  quo;
  logic [L-1:0]                      nq;
  rmq_div_pipe #(
    .LANES(L), .NUM_W(rmq_pkg::NUM_W), .DEN_W(rmq_pkg::DEN_W),
    .Q_W(rmq_pkg::QUO_W), .SIDE_W(L)
  ) u_norm_div (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(vd), .in_num(num_d), .in_den(den_d), .in_side(nd),
    .out_valid(vq), .out_quo(quo), .out_side(nq)
  );

  // saturate, apply sign, output register
  logic [L-1:0][15:0] q_out;
  always_comb begin
    logic [rmq_pkg::QUO_W-1:0] qs;
    for (int l = 0; l < L; l++) begin
      qs = (quo[l] > rmq_pkg::ONE_Q14) ? rmq_pkg::ONE_Q14 : quo[l];
      if (nq[l] && qs != '0) begin
        q_out[l] = 16'(-{1'b0, qs});
      end else begin
        q_out[l] = {1'b0, qs};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (en) begin
      m_tvalid <= vq;
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= q_out;
    end
  end

  // the largest term never takes a negative sign
  `ASSERT_RUN(a_big_positive, vb |-> !nb[bigb], "largest quaternion term marked negative")
  // one normalized term has magnitude from 8000 to 16384, close to half the length or more
  `ASSERT_RUN(a_unit_norm,
    m_tvalid |-> ((m_tdata[15:0] >= 16'd8000 && m_tdata[15:0] <= 16'd16384) ||
                  (m_tdata[31:16] >= 16'd8000 && m_tdata[31:16] <= 16'd16384) ||
                  (m_tdata[47:32] >= 16'd8000 && m_tdata[47:32] <= 16'd16384) ||
                  (m_tdata[63:48] >= 16'd8000 && m_tdata[63:48] <= 16'd16384) ||
                  (m_tdata[15:0] >= 16'hC000 && m_tdata[15:0] <= 16'hE0C0) ||
                  (m_tdata[31:16] >= 16'hC000 && m_tdata[31:16] <= 16'hE0C0) ||
                  (m_tdata[47:32] >= 16'hC000 && m_tdata[47:32] <= 16'hE0C0) ||
                  (m_tdata[63:48] >= 16'hC000 && m_tdata[63:48] <= 16'hE0C0)),
    "no quaternion term near unit scale")
  // reset empties the pipeline
  `ASSERT_ALL(a_reset_empty, rst |=> !m_tvalid && !vq && !vb, "pipeline not empty after reset")
endmodule

/* test/rotation_matrix_to_quaternion_tb.sv */
// Testbench for rotation_matrix_to_quaternion: streams 3x3 Q2.14 matrices in,
// predicts each normalized quaternion in software and compares in order.
// Depends on the DUT only.
`timescale 1ns / 1ps

class quat_scoreboard;
  logic [63:0] pending_quats[$];
  int errors;

  static function longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bt;
    res = 0;
    bt = 64'd1 << 62;
    while (bt > v) bt >>= 2;
    while (bt != 0) begin
      if (v >= res + bt) begin
        v -= res + bt;
        res = (res >> 1) + bt;
      end else begin
        res >>= 1;
      end
      bt >>= 2;
    end
    return res;
  endfunction

  function void note_matrix(logic [143:0] d);
    int m[9];
    int t[4];
    longint unsigned mag[4], sq, len, q;
    bit neg[4];
    int big;
    logic [63:0] quat;
    for (int i = 0; i < 9; i++) m[i] = $signed(d[16*i +: 16]);
    t[0] = 16384 + m[0] + m[4] + m[8];
    t[1] = 16384 + m[0] - m[4] - m[8];
    t[2] = 16384 - m[0] + m[4] - m[8];
    t[3] = 16384 - m[0] - m[4] + m[8];
    sq = 0;
    big = 0;
    neg = '{0, 0, 0, 0};
    for (int i = 0; i < 4; i++) begin
      if (t[i] < 0) t[i] = 0;
      mag[i] = int_sqrt(longint'(t[i]) << 12);
      sq += mag[i] * mag[i];
    end
    for (int i = 1; i < 4; i++) if (t[i] > t[big]) big = i;
    // m index: 0=m11 1=m12 2=m13 3=m21 4=m22 5=m23 6=m31 7=m32 8=m33
    case (big)
      0: begin
        neg[1] = (m[7] - m[5]) < 0;
        neg[2] = (m[2] - m[6]) < 0;
        neg[3] = (m[3] - m[1]) < 0;
      end
      1: begin
        neg[0] = (m[7] - m[5]) < 0;
        neg[2] = (m[3] + m[1]) < 0;
        neg[3] = (m[2] + m[6]) < 0;
      end
      2: begin
        neg[0] = (m[2] - m[6]) < 0;
        neg[1] = (m[3] + m[1]) < 0;
        neg[3] = (m[7] + m[5]) < 0;
      end
      default: begin
        neg[0] = (m[3] - m[1]) < 0;
        neg[1] = (m[6] + m[2]) < 0;
        neg[2] = (m[7] + m[5]) < 0;
      end
    endcase
    len = int_sqrt(sq << 16);
    if (len == 0) len = 1;
    for (int i = 0; i < 4; i++) begin
      q = ((mag[i] << 23) + len) / (2 * len);
      if (q > 16384) q = 16384;
      if (neg[i] && q != 0) q = 65536 - q;
      quat[16*i +: 16] = q[15:0];
    end
    pending_quats.push_back(quat);
  endfunction

  function void check_quat(logic [63:0] got);
    logic [63:0] exp_q;
    string names[4];
    names = '{"quat_w", "quat_x", "quat_y", "quat_z"};
    if (pending_quats.size() == 0) begin
      $error("unexpected output item %h", got);
      errors++;
      return;
    end
    exp_q = pending_quats.pop_front();
    for (int i = 0; i < 4; i++)
      if (got[16*i +: 16] !== exp_q[16*i +: 16]) begin
        $error("%s: expected %0d, got %0d", names[i], $signed(exp_q[16*i +: 16]),
               $signed(got[16*i +: 16]));
        errors++;
      end
  endfunction
endclass

module rotation_matrix_to_quaternion_tb;
  localparam int LATENCY = 61;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [143:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [63:0] m_tdata;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;
  int n_sent = 0;
  int n_checked = 0;
  quat_scoreboard sb = new();

  rotation_matrix_to_quaternion u_dut (.*);

  always #4 clk = ~clk;

  // receiver: sample at rising edge, drive ready at falling edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      sb.check_quat(m_tdata);
      n_checked++;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      m_tready <= 0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // valid stays up between back-to-back items and drops only while idling or draining
  task automatic send_matrix(logic [143:0] d);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk);
    end
    s_tdata <= d;
    s_tvalid <= 1;
    do @(posedge clk); while (!s_tready);
    sb.note_matrix(d);
    n_sent++;
    @(negedge clk);
  endtask

  task automatic send_elems(int a[9]);
    logic [143:0] d;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = a[i][15:0];
    send_matrix(d);
  endtask

  function automatic logic [143:0] rand_matrix();
    logic [143:0] d;
    int s;
    int ang_kind;
    for (int i = 0; i < 9; i++) d[16*i +: 16] = 16'($urandom());
    ang_kind = $urandom_range(3);
    // mostly near-rotations: one large signed entry per row in a random column, plus small noise
    if (ang_kind != 0) begin
      d = '0;
      for (int i = 0; i < 9; i++) begin
        s = $signed(16'($urandom_range(4095))) - 2048;
        d[16*i +: 16] = s[15:0];
      end
      for (int r = 0; r < 3; r++) begin
        s = $urandom_range(2) ? 16384 - $urandom_range(3000) : -16384 + $urandom_range(3000);
        d[16*(3*r + (($urandom_range(2) + r) % 3)) +: 16] = s[15:0];
      end
    end
    return d;
  endfunction

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pending_quats.size() != 0) @(negedge clk);
  endtask

  initial begin
    int e[9];
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    @(negedge clk);
    // directed: identity, 180 degree turns, extremes, ties, zero sign args
    e = '{16384, 0, 0, 0, 16384, 0, 0, 0, 16384}; send_elems(e);
    e = '{16384, 0, 0, 0, -16384, 0, 0, 0, -16384}; send_elems(e);
    e = '{-16384, 0, 0, 0, 16384, 0, 0, 0, -16384}; send_elems(e);
    e = '{-16384, 0, 0, 0, -16384, 0, 0, 0, 16384}; send_elems(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0}; send_elems(e);
    e = '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768};
    send_elems(e);
    e = '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767}; send_elems(e);
    e = '{32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767};
    send_elems(e);
    e = '{-32768, 32767, -32768, 32767, -32768, 32767, -32768, 32767, -32768};
    send_elems(e);
    e = '{0, -16384, 0, 16384, 0, 0, 0, 0, 16384}; send_elems(e);
    e = '{0, 16384, 0, -16384, 0, 0, 0, 0, 16384}; send_elems(e);
    e = '{0, 0, 16384, 0, 16384, 0, -16384, 0, 0}; send_elems(e);
    e = '{16384, 0, 0, 0, 0, -16384, 0, 16384, 0}; send_elems(e);
    e = '{16384, 0, 0, 0, 0, 16384, 0, -16384, 0}; send_elems(e);
    e = '{0, 0, 0, 0, 0, 0, 0, 0, -16384}; send_elems(e);
    e = '{8192, 100, -100, -100, 8192, 100, 100, -100, 8192}; send_elems(e);
    e = '{-5461, 7, 7, 7, -5461, 7, 7, 7, -5461}; send_elems(e);
    e = '{0, 5, 5, -5, 0, -5, -5, 5, 0}; send_elems(e);
    e = '{-16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384, -16384};
    send_elems(e);
    drain();
    // random phases: none, sender idle, receiver stall, both
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 45) : 0;
      recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 24 : 45) : 0;
      if (ph == 1) hold_cycles = 200;  // block fills and back-pressures input
      for (int i = 0; i < 480; i++) send_matrix(rand_matrix());
      if (ph == 2) drain();  // sender waits for everything to come back
    end
    fork
      begin
        drain();
        repeat (LATENCY + 10) @(posedge clk);
      end
      begin
        #2ms;
        $display("rotation_matrix_to_quaternion verification failed");
        $finish;
      end
    join_any
    $display("Covered %0d matrices, %0d quaternions checked, with idle and stall phases.",
             n_sent, n_checked);
    if (sb.errors == 0 && sb.pending_quats.size() == 0)
      $display("rotation_matrix_to_quaternion verification clean");
    else
      $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("rotation_matrix_to_quaternion verification failed");
    $finish;
  end
endmodule
